// ----- rtl/rbst_pkg.sv -----
// ----------------------------------------------------------------------------
// rbst_pkg
// Types and constants shared by the ray versus box slab test pipeline.
// ----------------------------------------------------------------------------
package rbst_pkg;

    localparam int EPS_W = 16;
    localparam logic [EPS_W-1:0] EPS_RESET = 16'd1;

    // Two-bit signed face normal codes.
    localparam logic [1:0] NRM_ZERO = 2'b00;
    localparam logic [1:0] NRM_POS  = 2'b01;
    localparam logic [1:0] NRM_NEG  = 2'b11;

    // Per-item control flags that travel alongside the dividers.
    typedef struct packed {
        logic valid;
        logic par_x;
        logic par_y;
        logic pmiss_x;
        logic pmiss_y;
    } rbst_ctl_t;

endpackage

// ----- rtl/rbst_front.sv -----
// ----------------------------------------------------------------------------
// rbst_front
// Input stage: direction, parallel detection, slab numerators and signs.
// ----------------------------------------------------------------------------
module rbst_front import rbst_pkg::*; #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [EPS_W-1:0]              eps,
    input  logic signed [COORD_WIDTH-1:0] start_x,
    input  logic signed [COORD_WIDTH-1:0] start_y,
    input  logic signed [COORD_WIDTH-1:0] end_x,
    input  logic signed [COORD_WIDTH-1:0] end_y,
    input  logic signed [COORD_WIDTH-1:0] box_low_x,
    input  logic signed [COORD_WIDTH-1:0] box_low_y,
    input  logic signed [COORD_WIDTH-1:0] box_high_x,
    input  logic signed [COORD_WIDTH-1:0] box_high_y,
    output rbst_ctl_t                     ctl,
    output logic [COORD_WIDTH:0]          den_x,
    output logic [COORD_WIDTH:0]          den_y,
    output logic [COORD_WIDTH:0]          nlo_x,
    output logic [COORD_WIDTH:0]          nhi_x,
    output logic [COORD_WIDTH:0]          nlo_y,
    output logic [COORD_WIDTH:0]          nhi_y,
    output logic                          neg_lo_x,
    output logic                          neg_hi_x,
    output logic                          neg_lo_y,
    output logic                          neg_hi_y
);

    localparam int W = COORD_WIDTH;

    logic signed [W:0] dx, dy, lox, hix, loy, hiy;
    logic [W:0] mdx, mdy;
    logic [W:0] eps_ext;
    rbst_ctl_t ctl_next;

    function automatic logic [W:0] mag(input logic signed [W:0] v);
        mag = v[W] ? (~v + 1'b1) : v;
    endfunction

    always_comb begin
        dx  = {end_x[W-1], end_x} - {start_x[W-1], start_x};
        dy  = {end_y[W-1], end_y} - {start_y[W-1], start_y};
        lox = {box_low_x[W-1], box_low_x} - {start_x[W-1], start_x};
        hix = {box_high_x[W-1], box_high_x} - {start_x[W-1], start_x};
        loy = {box_low_y[W-1], box_low_y} - {start_y[W-1], start_y};
        hiy = {box_high_y[W-1], box_high_y} - {start_y[W-1], start_y};
        mdx = mag(dx);
        mdy = mag(dy);
        eps_ext = {{(W+1-EPS_W){1'b0}}, eps};
        ctl_next.valid   = in_valid;
        ctl_next.par_x   = (dx == '0) || (mdx < eps_ext);
        ctl_next.par_y   = (dy == '0) || (mdy < eps_ext);
        ctl_next.pmiss_x = (start_x < box_low_x) || (box_high_x < start_x);
        ctl_next.pmiss_y = (start_y < box_low_y) || (box_high_y < start_y);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl <= '0;
        end else if (en) begin
            ctl <= ctl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            den_x    <= mdx;
            den_y    <= mdy;
            nlo_x    <= mag(lox);
            nhi_x    <= mag(hix);
            nlo_y    <= mag(loy);
            nhi_y    <= mag(hiy);
            neg_lo_x <= lox[W] ^ dx[W];
            neg_hi_x <= hix[W] ^ dx[W];
            neg_lo_y <= loy[W] ^ dy[W];
            neg_hi_y <= hiy[W] ^ dy[W];
        end
    end

endmodule

// ----- rtl/rbst_div.sv -----
// ----------------------------------------------------------------------------
// rbst_div
// Pipelined restoring divider, one quotient bit per stage, with a final
// stage that applies the sign and saturates to the coordinate range.
// ----------------------------------------------------------------------------
module rbst_div import rbst_pkg::*; #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                          aclk,
    input  logic                          en,
    input  logic [COORD_WIDTH:0]          num_mag,
    input  logic [COORD_WIDTH:0]          den_mag,
    input  logic                          neg,
    output logic signed [COORD_WIDTH-1:0] quo
);

    localparam int W  = COORD_WIDTH;
    localparam int NB = COORD_WIDTH + FRAC_BITS + 1;
    localparam int RW = COORD_WIDTH + 1;

    logic [RW-1:0] rem_reg [NB];
    logic [NB-1:0] dvd_reg [NB];
    logic [NB-1:0] q_reg   [NB];
    logic [RW-1:0] den_reg [NB];
    logic          neg_reg [NB];

    for (genvar k = 0; k < NB; k++) begin : g_stage
        logic [RW-1:0] rem_in, den_in;
        logic [NB-1:0] dvd_in, q_in;
        logic          neg_in;
        logic [RW:0]   trial;
        logic          ge;

        if (k == 0) begin : g_first
            assign rem_in = '0;
            assign dvd_in = {num_mag, {FRAC_BITS{1'b0}}};
            assign q_in   = '0;
            assign den_in = den_mag;
            assign neg_in = neg;
        end else begin : g_next
            assign rem_in = rem_reg[k-1];
            assign dvd_in = dvd_reg[k-1];
            assign q_in   = q_reg[k-1];
            assign den_in = den_reg[k-1];
            assign neg_in = neg_reg[k-1];
        end

        assign trial = {rem_in, dvd_in[NB-1]};
        assign ge    = trial >= {1'b0, den_in};

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= ge ? RW'(trial - {1'b0, den_in}) : trial[RW-1:0];
                dvd_reg[k] <= {dvd_in[NB-2:0], 1'b0};
                q_reg[k]   <= {q_in[NB-2:0], ge};
                den_reg[k] <= den_in;
                neg_reg[k] <= neg_in;
            end
        end
    end

    logic [NB-1:0] q_mag;
    logic          ovf;
    logic signed [W-1:0] quo_next;

    always_comb begin
        q_mag = q_reg[NB-1];
        ovf   = |q_mag[NB-1:W-1];
        if (neg_reg[NB-1]) begin
            quo_next = ovf ? {1'b1, {(W-1){1'b0}}} : W'(~q_mag[W-1:0] + 1'b1);
        end else begin
            quo_next = ovf ? {1'b0, {(W-1){1'b1}}} : q_mag[W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            quo <= quo_next;
        end
    end

endmodule

// ----- rtl/rbst_combine.sv -----
// ----------------------------------------------------------------------------
// rbst_combine
// Slab interval logic: per-axis ordering, entry and exit narrowing, and the
// final hit decision.
// ----------------------------------------------------------------------------
module rbst_combine import rbst_pkg::*; #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  rbst_ctl_t                     ctl,
    input  logic signed [COORD_WIDTH-1:0] max_frac,
    input  logic signed [COORD_WIDTH-1:0] t1x,
    input  logic signed [COORD_WIDTH-1:0] t2x,
    input  logic signed [COORD_WIDTH-1:0] t1y,
    input  logic signed [COORD_WIDTH-1:0] t2y,
    output logic                          res_valid,
    output logic                          res_hit,
    output logic signed [COORD_WIDTH-1:0] res_frac,
    output logic [1:0]                    res_nx,
    output logic [1:0]                    res_ny
);

    localparam int W = COORD_WIDTH;

    // Ordering stage.
    rbst_ctl_t ctl_b_reg;
    logic signed [W-1:0] lox_reg, hix_reg, loy_reg, hiy_reg, maxb_reg;
    logic [1:0] sx_reg, sy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_b_reg <= '0;
        end else if (en) begin
            ctl_b_reg <= ctl;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lox_reg  <= (t1x > t2x) ? t2x : t1x;
            hix_reg  <= (t1x > t2x) ? t1x : t2x;
            sx_reg   <= (t1x > t2x) ? NRM_POS : NRM_NEG;
            loy_reg  <= (t1y > t2y) ? t2y : t1y;
            hiy_reg  <= (t1y > t2y) ? t1y : t2y;
            sy_reg   <= (t1y > t2y) ? NRM_POS : NRM_NEG;
            maxb_reg <= max_frac;
        end
    end

    // Narrowing stage: x axis first, then y.
    logic valid_c_reg;
    logic miss_c_reg, miss_c_next;
    logic have_c_reg, have_c_next;
    logic signed [W-1:0] entry_c_reg, entry_c_next, exit_c_reg, exit_c_next, maxc_reg;
    logic [1:0] nx_c_reg, nx_c_next, ny_c_reg, ny_c_next;

    always_comb begin
        miss_c_next  = 1'b0;
        have_c_next  = 1'b0;
        entry_c_next = lox_reg;
        exit_c_next  = hix_reg;
        nx_c_next    = NRM_ZERO;
        ny_c_next    = NRM_ZERO;
        if (ctl_b_reg.par_x) begin
            miss_c_next = ctl_b_reg.pmiss_x;
        end else begin
            have_c_next = 1'b1;
            nx_c_next   = sx_reg;
        end
        if (ctl_b_reg.par_y) begin
            miss_c_next = miss_c_next | ctl_b_reg.pmiss_y;
        end else begin
            if (!have_c_next || (loy_reg > lox_reg)) begin
                entry_c_next = loy_reg;
                nx_c_next    = NRM_ZERO;
                ny_c_next    = sy_reg;
            end
            if (!have_c_next || (hiy_reg < hix_reg)) begin
                exit_c_next = hiy_reg;
            end
            have_c_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_c_reg <= 1'b0;
        end else if (en) begin
            valid_c_reg <= ctl_b_reg.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            miss_c_reg  <= miss_c_next;
            have_c_reg  <= have_c_next;
            entry_c_reg <= entry_c_next;
            exit_c_reg  <= exit_c_next;
            nx_c_reg    <= nx_c_next;
            ny_c_reg    <= ny_c_next;
            maxc_reg    <= maxb_reg;
        end
    end

    // Decision, registered by the output stage of the top level.
    always_comb begin
        res_valid = valid_c_reg;
        res_hit   = !miss_c_reg && have_c_reg && !(entry_c_reg > exit_c_reg)
                    && !entry_c_reg[W-1] && !(maxc_reg < entry_c_reg);
        res_frac  = entry_c_reg;
        res_nx    = nx_c_reg;
        res_ny    = ny_c_reg;
    end

endmodule

// ----- rtl/ray_box_slab_test.sv -----
// ----------------------------------------------------------------------------
// ray_box_slab_test
// Two-dimensional ray segment versus axis-aligned box test, slab method.
// ----------------------------------------------------------------------------
// Usage: one ray/box pair enters on the s_ stream per transaction and one
// result leaves on the m_ stream per transaction, in the same order. The
// input transaction carries the nine coordinates packed into s_tdata; the
// result carries hit, hit fraction and the face normal in m_tdata.
// The parallel threshold is written through cfg_valid/cfg_ready/cfg_data,
// which is always ready; write it only while no item is in flight.
// The pipeline depth is set mostly by the four restoring dividers, which
// produce one quotient bit per stage. One item is accepted every cycle
// while the output side is not stalled by m_tready.
// Reset (aresetn low, synchronous) empties the pipeline and sets the
// threshold to 1. When the receiver holds m_tready low with a result
// waiting, the whole pipeline holds and s_tready falls; nothing is lost.
// On a miss, the fraction and normal fields are zero.
// ----------------------------------------------------------------------------
module ray_box_slab_test import rbst_pkg::*; #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16,
    localparam int S_TDATA_W  = ((9 * COORD_WIDTH + 7) / 8) * 8,
    localparam int M_TDATA_W  = ((COORD_WIDTH + 5 + 7) / 8) * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [EPS_W-1:0]     cfg_data,    // parallel_epsilon
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // start_x, start_y, end_x, end_y, max_fraction, box_low_x, box_low_y,
    // box_high_x, box_high_y
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // hit, hit_fraction, normal_x, normal_y, zero padding
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int W       = COORD_WIDTH;
    localparam int DIV_LAT = COORD_WIDTH + FRAC_BITS + 2;

    logic en;
    logic [EPS_W-1:0] eps_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eps_reg <= EPS_RESET;
        end else if (cfg_valid) begin
            eps_reg <= cfg_data;
        end
    end

    logic m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    rbst_ctl_t ctl_f;
    logic [W:0] den_x, den_y, nlo_x, nhi_x, nlo_y, nhi_y;
    logic neg_lo_x, neg_hi_x, neg_lo_y, neg_hi_y;
    logic signed [W-1:0] maxf_f_reg;

    rbst_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (s_tvalid),
        .eps        (eps_reg),
        .start_x    (s_tdata[0*W +: W]),
        .start_y    (s_tdata[1*W +: W]),
        .end_x      (s_tdata[2*W +: W]),
        .end_y      (s_tdata[3*W +: W]),
        .box_low_x  (s_tdata[5*W +: W]),
        .box_low_y  (s_tdata[6*W +: W]),
        .box_high_x (s_tdata[7*W +: W]),
        .box_high_y (s_tdata[8*W +: W]),
        .ctl        (ctl_f),
        .den_x      (den_x),
        .den_y      (den_y),
        .nlo_x      (nlo_x),
        .nhi_x      (nhi_x),
        .nlo_y      (nlo_y),
        .nhi_y      (nhi_y),
        .neg_lo_x   (neg_lo_x),
        .neg_hi_x   (neg_hi_x),
        .neg_lo_y   (neg_lo_y),
        .neg_hi_y   (neg_hi_y)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            maxf_f_reg <= s_tdata[4*W +: W];
        end
    end

    logic signed [W-1:0] t1x, t2x, t1y, t2y;

    rbst_div #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div_lo_x (
        .aclk(aclk), .en(en), .num_mag(nlo_x), .den_mag(den_x), .neg(neg_lo_x), .quo(t1x)
    );
    rbst_div #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div_hi_x (
        .aclk(aclk), .en(en), .num_mag(nhi_x), .den_mag(den_x), .neg(neg_hi_x), .quo(t2x)
    );
    rbst_div #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div_lo_y (
        .aclk(aclk), .en(en), .num_mag(nlo_y), .den_mag(den_y), .neg(neg_lo_y), .quo(t1y)
    );
    rbst_div #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div_hi_y (
        .aclk(aclk), .en(en), .num_mag(nhi_y), .den_mag(den_y), .neg(neg_hi_y), .quo(t2y)
    );

    // Control flags and the fraction limit follow the dividers stage by stage.
    rbst_ctl_t           ctl_d_reg  [DIV_LAT];
    logic signed [W-1:0] maxf_d_reg [DIV_LAT];

    for (genvar k = 0; k < DIV_LAT; k++) begin : g_side
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                ctl_d_reg[k] <= '0;
            end else if (en) begin
                ctl_d_reg[k] <= (k == 0) ? ctl_f : ctl_d_reg[(k == 0) ? 0 : k-1];
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                maxf_d_reg[k] <= (k == 0) ? maxf_f_reg : maxf_d_reg[(k == 0) ? 0 : k-1];
            end
        end
    end

    logic res_valid, res_hit;
    logic signed [W-1:0] res_frac;
    logic [1:0] res_nx, res_ny;

    rbst_combine #(.COORD_WIDTH(COORD_WIDTH)) u_combine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .ctl       (ctl_d_reg[DIV_LAT-1]),
        .max_frac  (maxf_d_reg[DIV_LAT-1]),
        .t1x       (t1x),
        .t2x       (t2x),
        .t1y       (t1y),
        .t2y       (t2y),
        .res_valid (res_valid),
        .res_hit   (res_hit),
        .res_frac  (res_frac),
        .res_nx    (res_nx),
        .res_ny    (res_ny)
    );

    logic [M_TDATA_W-1:0] m_tdata_next;

    always_comb begin
        m_tdata_next = '0;
        if (res_hit) begin
            m_tdata_next[0]       = 1'b1;
            m_tdata_next[W:1]     = res_frac;
            m_tdata_next[W+2:W+1] = res_nx;
            m_tdata_next[W+4:W+3] = res_ny;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    // A waiting result must block the input side.
    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input accepted while the output is stalled");

    // A miss carries no fraction and no normal.
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[M_TDATA_W-1:1] == '0))
        else $error("miss result with non-zero fields");

    // A hit names exactly one entered face.
    a_hit_one_face: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[0]) |->
            ((m_tdata[W+2:W+1] != NRM_ZERO) != (m_tdata[W+4:W+3] != NRM_ZERO)))
        else $error("hit without exactly one face normal");

    // A hit fraction is never negative.
    a_hit_frac_sign: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[0]) |-> !m_tdata[W])
        else $error("negative hit fraction");

endmodule

// ----- tb/sv/tb_ray_box_slab_test.sv -----
// ----------------------------------------------------------------------------
// tb_ray_box_slab_test
// Drives ray/box pairs into the slab test pipeline under random idling on
// both streams, predicts each hit, fraction and normal, and checks the
// results in order. The parallel threshold is changed between phases.
// ----------------------------------------------------------------------------
module tb_ray_box_slab_test;
    import rbst_pkg::*;

    localparam int CW = 32;
    localparam int FB = 16;
    localparam int S_W = ((9 * CW + 7) / 8) * 8;
    localparam int M_W = ((CW + 5 + 7) / 8) * 8;
    localparam int LATENCY = CW + FB + 6;

    typedef struct packed {
        logic            hit;
        logic [CW-1:0]   frac;
        logic [1:0]      nx;
        logic [1:0]      ny;
    } slab_result_t;

    typedef logic signed [CW-1:0] coord_t;

    class slab_scoreboard;
        slab_result_t pending[$];
        int mismatches;
        logic [EPS_W-1:0] eps;

        function logic signed [63:0] quot(logic signed [63:0] num,
                                          logic signed [63:0] den);
            logic signed [63:0] q;
            q = (num * 64'sd65536) / den;
            if (q > 64'sd2147483647) q = 64'sd2147483647;
            if (q < -64'sd2147483648) q = -64'sd2147483648;
            return q;
        endfunction

        function void note_ray(coord_t f[9]);
            logic signed [63:0] st[2], en[2], lo[2], hi[2], d, mag, t1, t2, tin, tout, mf;
            logic [1:0] nrm[2];
            logic [1:0] sgn;
            bit have_in, ok;
            slab_result_t r;
            st[0] = f[0]; st[1] = f[1]; en[0] = f[2]; en[1] = f[3]; mf = f[4];
            lo[0] = f[5]; lo[1] = f[6]; hi[0] = f[7]; hi[1] = f[8];
            nrm[0] = NRM_ZERO; nrm[1] = NRM_ZERO;
            have_in = 0; ok = 1; tin = 0; tout = 0;
            for (int a = 0; a < 2 && ok; a++) begin
                d = en[a] - st[a];
                mag = (d < 0) ? -d : d;
                if (d == 0 || mag < eps) begin
                    if (st[a] < lo[a] || hi[a] < st[a]) ok = 0;
                end else begin
                    t1 = quot(lo[a] - st[a], d);
                    t2 = quot(hi[a] - st[a], d);
                    sgn = NRM_NEG;
                    if (t1 > t2) begin
                        mag = t1; t1 = t2; t2 = mag; sgn = NRM_POS;
                    end
                    if (!have_in || t1 > tin) begin
                        nrm[0] = NRM_ZERO; nrm[1] = NRM_ZERO; nrm[a] = sgn;
                        tin = t1;
                    end
                    // The exit is first set on the same axis as the entry.
                    if (!have_in || t2 < tout) tout = t2;
                    have_in = 1;
                    if (tin > tout) ok = 0;
                end
            end
            if (ok && (!have_in || tin < 0 || mf < tin)) ok = 0;
            r = '0;
            if (ok) begin
                r.hit = 1; r.frac = tin[CW-1:0]; r.nx = nrm[0]; r.ny = nrm[1];
            end
            pending.push_back(r);
        endfunction

        function void check_result(logic [M_W-1:0] data);
            slab_result_t got, want;
            got.hit = data[0]; got.frac = data[CW:1];
            got.nx = data[CW+2:CW+1]; got.ny = data[CW+4:CW+3];
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result %h", data);
                return;
            end
            want = pending.pop_front();
            if (got !== want || data[M_W-1:CW+5] !== '0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"Mismatch: expected hit %0d frac %h n %0d,%0d;",
                              " got hit %0d frac %h n %0d,%0d"},
                             want.hit, want.frac, $signed(want.nx), $signed(want.ny),
                             got.hit, got.frac, $signed(got.nx), $signed(got.ny));
            end
        endfunction
    endclass

    logic aclk = 0, aresetn = 0;
    logic cfg_valid = 0, cfg_ready;
    logic [EPS_W-1:0] cfg_data = '0;
    logic s_tvalid = 0, s_tready;
    logic [S_W-1:0] s_tdata = '0;
    logic m_tvalid, m_tready = 0;
    logic [M_W-1:0] m_tdata;
    bit sink_busy = 1;

    slab_scoreboard board;

    ray_box_slab_test i_dut (.*);

    initial forever #2 aclk = ~aclk;

    initial begin
        #4000000;
        $display("Some tests failed");
        $finish;
    end

    task automatic write_epsilon(logic [EPS_W-1:0] v);
        cfg_valid <= 1; cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 0;
        board.eps = v;
    endtask

    // The valid line stays high after a transaction; a gap in the next call or
    // an explicit idle lowers it, so that it is assigned once per time step.
    task automatic send_ray(coord_t f[9]);
        int gap;
        logic [S_W-1:0] data;
        gap = $urandom_range(0, 17);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
        data = '0;
        for (int i = 0; i < 9; i++) data[i*CW +: CW] = f[i];
        s_tdata <= data;
        s_tvalid <= 1;
        do @(posedge aclk); while (!s_tready);
        board.note_ray(f);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    function automatic coord_t rnd_coord();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'sh7fffffff - $urandom_range(0, 3);
            2: return 32'sh80000000 + $urandom_range(0, 3);
            default: return $signed($urandom_range(0, 32'h000a0000)) - 32'sh00050000;
        endcase
    endfunction

    // Mostly rays aimed through small boxes, so that hits are common.
    task automatic random_ray();
        coord_t f[9];
        coord_t bx, by, w, h;
        if ($urandom_range(0, 4) == 0) begin
            foreach (f[i]) f[i] = rnd_coord();
        end else begin
            bx = $signed($urandom_range(0, 32'h00080000)) - 32'sh00040000;
            by = $signed($urandom_range(0, 32'h00080000)) - 32'sh00040000;
            w = $urandom_range(0, 32'h00040000);
            h = $urandom_range(0, 32'h00040000);
            if ($urandom_range(0, 15) == 0) w = -w;
            f[5] = bx; f[6] = by; f[7] = bx + w; f[8] = by + h;
            f[0] = rnd_coord(); f[1] = rnd_coord();
            f[2] = bx + $urandom_range(0, w > 0 ? w : 0);
            f[3] = by + $urandom_range(0, h);
            if ($urandom_range(0, 3) == 0) f[2] = f[0] + $urandom_range(0, 3);
            if ($urandom_range(0, 3) == 0) f[3] = f[1] - $urandom_range(0, 3);
            f[4] = ($urandom_range(0, 3) == 0) ? rnd_coord()
                                               : $urandom_range(0, 32'h00020000);
        end
        send_ray(f);
    endtask

    initial begin
        coord_t f[9];
        board = new();
        board.eps = EPS_RESET;
        repeat (12) @(posedge aclk);
        aresetn <= 1;
        sink_busy = 0;
        @(posedge aclk);

        // Directed: hits on each face, parallel hits and misses, extremes.
        f = '{-32'sh20000, 32'sh8000, 32'sh20000, 32'sh8000, 32'sh10000,
              0, 0, 32'sh10000, 32'sh10000};
        send_ray(f);
        f = '{32'sh30000, 32'sh8000, -32'sh10000, 32'sh8000, 32'sh10000,
              0, 0, 32'sh10000, 32'sh10000};
        send_ray(f);
        f = '{32'sh8000, -32'sh20000, 32'sh8000, 32'sh20000, 32'sh10000,
              0, 0, 32'sh10000, 32'sh10000};
        send_ray(f);
        f = '{32'sh8000, 32'sh30000, 32'sh9000, -32'sh10000, 32'sh10000,
              0, 0, 32'sh10000, 32'sh10000};
        send_ray(f);
        f = '{32'sh8000, 32'sh8000, 32'sh8000, 32'sh8000, 32'sh10000,
              0, 0, 32'sh10000, 32'sh10000};
        send_ray(f);
        f = '{32'sh20000, 32'sh8000, 32'sh20000, 32'sh9000, 32'sh10000,
              0, 0, 32'sh10000, 32'sh10000};
        send_ray(f);
        f = '{32'sh8000, 32'sh8000, 32'sh30000, 32'sh8000, 32'sh10000,
              32'sh10000, 0, 0, 32'sh10000};
        send_ray(f);
        f = '{-32'sh80000000, -32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
              32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
              32'sh7fffffff};
        send_ray(f);
        f = '{0, 0, 1, 1, 32'sh7fffffff, -32'sh80000000, -32'sh80000000,
              32'sh7fffffff, 32'sh7fffffff};
        send_ray(f);
        f = '{32'sh7fffffff, 0, -32'sh80000000, 0, -32'sh80000000,
              0, 0, 1, 1};
        send_ray(f);
        f = '{-32'sh10000, 32'sh8000, 32'sh10000, 32'sh8000, 0,
              0, 0, 32'sh10000, 32'sh10000};
        send_ray(f);
        f = '{-1, -1, -1, -1, -1, -1, -1, -1, -1};
        send_ray(f);
        drain();

        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: write_epsilon(16'd0);
                1: write_epsilon(16'hffff);
                2: write_epsilon(16'h8000);
                3: write_epsilon(EPS_W'($urandom));
                default: write_epsilon(16'd1);
            endcase
            f = '{0, 0, 32'sh1, 32'sh7fff, 32'sh7fffffff, -32'sh10000, -32'sh10000,
                  32'sh10000, 32'sh10000};
            send_ray(f);
            for (int n = 0; n < 140; n++) begin
                random_ray();
                if (n == 70) begin
                    s_tvalid <= 0;
                    while (board.pending.size() != 0) @(posedge aclk);
                end
            end
            drain();
        end
        sink_busy = 1;

        if (board.mismatches == 0 && board.pending.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Result side: random stall before each transaction, with runs of none.
    initial begin
        int stall;
        @(posedge aclk);
        while (sink_busy) @(posedge aclk);
        forever begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
            if (stall != 0) begin
                m_tready <= 0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1;
            do @(posedge aclk); while (!m_tvalid);
            board.check_result(m_tdata);
        end
    end

endmodule
